[design/box_intersection_over_union_top_defines.svh]
// assertion macros shared by the iou checker
// expects clk in the scope of every use, and arst_n in the scope of every BIOU_ASSERT
`ifndef BOX_INTERSECTION_OVER_UNION_TOP_DEFINES_SVH
`define BOX_INTERSECTION_OVER_UNION_TOP_DEFINES_SVH

// checked only while out of reset
`define BIOU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define BIOU_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/biou_pkg.sv]
// shared widths and control types of the box iou block
// no dependencies
`default_nettype none

package biou_pkg;

	localparam int THR_W      = 17;                    // threshold register width
	localparam int IOU_W      = 17;                    // iou field width
	localparam int OUT_FLD_W  = IOU_W + 2;             // iou, match, empty
	localparam int OUT_W      = ((OUT_FLD_W + 7) / 8) * 8;

	// control that travels with each item through the divider
	typedef struct packed {
		logic valid;
		logic empty;
	} div_ctl_t;

endpackage

`default_nettype wire

[design/biou_div.sv]
// pipelined restoring divider, one quotient bit per stage, stall by stage
// depends on biou_pkg
`default_nettype none

module biou_div
	import biou_pkg::*;
#(
	parameter int UW = 25,   // divisor width
	parameter int QW = 17    // quotient bits, also the stage count
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire div_ctl_t         in_ctl,
	output logic                  in_ready,
	input  wire logic [UW-2:0]    num,
	input  wire logic [UW-1:0]    den,
	output div_ctl_t              out_ctl,
	input  wire logic             out_ready,
	output logic      [QW-1:0]    quot,
	output logic      [UW-1:0]    rem
);

	logic [QW-1:0] vld_s;
	logic [QW-1:0] emp_s;
	logic [UW-1:0] den_s  [QW];
	logic [UW-1:0] rem_s  [QW];
	logic [QW-1:0] quot_s [QW];

	logic [QW:0]   en;
	logic [QW-1:0] pv;
	logic [QW-1:0] pemp;
	logic [UW-1:0] pden  [QW];
	logic [UW:0]   trial [QW];
	logic [QW-1:0] pquot [QW];
	logic [UW:0]   diff  [QW];
	logic [QW-1:0] ge;
	logic [UW-1:0] rem_nx  [QW];
	logic [QW-1:0] quot_nx [QW];

	// a stage takes a new item when it is empty or its item moves on
	always_comb begin
		en[QW] = out_ready;
		for (int k = QW - 1; k >= 0; k--) begin
			en[k] = ~vld_s[k] | en[k+1];
		end
	end

	// first stage compares the bare numerator, as inter never exceeds union
	always_comb begin
		pv[0]    = in_ctl.valid;
		pemp[0]  = in_ctl.empty;
		pden[0]  = den;
		pquot[0] = '0;
		trial[0] = {2'b00, num};
		for (int k = 1; k < QW; k++) begin
			pv[k]    = vld_s[k-1];
			pemp[k]  = emp_s[k-1];
			pden[k]  = den_s[k-1];
			pquot[k] = quot_s[k-1];
			trial[k] = {rem_s[k-1], 1'b0};
		end
		for (int k = 0; k < QW; k++) begin
			diff[k]    = trial[k] - {1'b0, pden[k]};
			ge[k]      = trial[k] >= {1'b0, pden[k]};
			rem_nx[k]  = ge[k] ? diff[k][UW-1:0] : trial[k][UW-1:0];
			quot_nx[k] = {pquot[k][QW-2:0], ge[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < QW; k++) begin
				if (en[k]) begin
					vld_s[k] <= pv[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < QW; k++) begin
			if (en[k]) begin
				emp_s[k]  <= pemp[k];
				den_s[k]  <= pden[k];
				rem_s[k]  <= rem_nx[k];
				quot_s[k] <= quot_nx[k];
			end
		end
	end

	assign in_ready      = en[0];
	assign out_ctl.valid = vld_s[QW-1];
	assign out_ctl.empty = emp_s[QW-1];
	assign quot          = quot_s[QW-1];
	assign rem           = rem_s[QW-1];

endmodule

`default_nettype wire

[design/box_intersection_over_union_top.sv]
// path from input item to result item: edges, products, union,
//   one divider stage per quotient bit, output register
// throughput: one item per cycle; each stage stalls only when the next one is full
// reset clears all valid bits and sets match_threshold to one half
// top level of the box iou block: stream in, stream out, threshold register
// depends on biou_pkg and biou_div
`default_nettype none

module box_intersection_over_union_top
	import biou_pkg::*;
#(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    cfg_we,
	input  wire logic [THR_W-1:0]                        cfg_wdata,     // match_threshold
	input  wire logic                                    s_axis_tvalid,
	output logic                                         s_axis_tready,
	// box_a_x, box_a_y, box_a_w, box_a_h, box_b_x, box_b_y, box_b_w, box_b_h
	input  wire logic [((8*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
	output logic                                         m_axis_tvalid,
	input  wire logic                                    m_axis_tready,
	output logic [OUT_W-1:0]                             m_axis_tdata   // iou_ratio, is_match, empty_union
);

	localparam int CB = COORD_BITS;
	localparam int AW = 2 * CB;          // area width
	localparam int UW = AW + 1;          // union width
	localparam int QW = FRAC_BITS + 1;   // quotient width
	localparam int CW = (QW > THR_W) ? QW : THR_W;
	localparam logic [THR_W-1:0] THR_RST = THR_W'(1) << (FRAC_BITS - 1);

	logic [THR_W-1:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RST;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// stage 1: edges and overlap spans
	logic [CB-1:0] ax, ay, aw, ah, bx, by, bw, bh;
	logic [CB:0]   ar, ab, br, bb, hi_x, hi_y;
	logic [CB-1:0] lo_x, lo_y, iw_nx, ih_nx;

	assign ax = s_axis_tdata[0*CB +: CB];
	assign ay = s_axis_tdata[1*CB +: CB];
	assign aw = s_axis_tdata[2*CB +: CB];
	assign ah = s_axis_tdata[3*CB +: CB];
	assign bx = s_axis_tdata[4*CB +: CB];
	assign by = s_axis_tdata[5*CB +: CB];
	assign bw = s_axis_tdata[6*CB +: CB];
	assign bh = s_axis_tdata[7*CB +: CB];

	always_comb begin
		ar    = {1'b0, ax} + {1'b0, aw};
		ab    = {1'b0, ay} + {1'b0, ah};
		br    = {1'b0, bx} + {1'b0, bw};
		bb    = {1'b0, by} + {1'b0, bh};
		lo_x  = (ax > bx) ? ax : bx;
		lo_y  = (ay > by) ? ay : by;
		hi_x  = (ar < br) ? ar : br;
		hi_y  = (ab < bb) ? ab : bb;
		// a span never exceeds the narrower box, so it fits CB bits
		iw_nx = (hi_x > {1'b0, lo_x}) ? CB'(hi_x - {1'b0, lo_x}) : '0;
		ih_nx = (hi_y > {1'b0, lo_y}) ? CB'(hi_y - {1'b0, lo_y}) : '0;
	end

	logic          v_s1, v_s2, v_s3;
	logic          en_s1, en_s2, en_s3;
	logic [CB-1:0] iw_s1, ih_s1, aw_s1, ah_s1, bw_s1, bh_s1;
	logic [AW-1:0] inter_s2, area_a_s2, area_b_s2;
	logic [AW-1:0] inter_s3;
	logic [UW-1:0] uni_s3, uni_nx;
	logic          emp_s3;

	div_ctl_t      div_in_ctl, div_out_ctl;
	logic          div_in_ready;
	logic [QW-1:0] div_quot;
	logic [UW-1:0] div_rem;

	logic             out_vld_q, en_o;
	logic [IOU_W-1:0] iou_q;
	logic             match_q, empty_q;

	assign en_o          = ~out_vld_q | m_axis_tready;
	assign en_s3         = ~v_s3 | div_in_ready;
	assign en_s2         = ~v_s2 | en_s3;
	assign en_s1         = ~v_s1 | en_s2;
	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= s_axis_tvalid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	assign uni_nx = {1'b0, area_a_s2} + {1'b0, area_b_s2} - {1'b0, inter_s2};

	always_ff @(posedge clk) begin
		if (en_s1) begin
			iw_s1 <= iw_nx;
			ih_s1 <= ih_nx;
			aw_s1 <= aw;
			ah_s1 <= ah;
			bw_s1 <= bw;
			bh_s1 <= bh;
		end
		// stage 2: intersection and both areas
		if (en_s2) begin
			inter_s2  <= AW'(iw_s1) * AW'(ih_s1);
			area_a_s2 <= AW'(aw_s1) * AW'(ah_s1);
			area_b_s2 <= AW'(bw_s1) * AW'(bh_s1);
		end
		// stage 3: union
		if (en_s3) begin
			inter_s3 <= inter_s2;
			uni_s3   <= uni_nx;
			emp_s3   <= (uni_nx == '0);
		end
	end

	assign div_in_ctl.valid = v_s3;
	assign div_in_ctl.empty = emp_s3;

	biou_div #(
		.UW (UW),
		.QW (QW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ctl    (div_in_ctl),
		.in_ready  (div_in_ready),
		.num       (inter_s3),
		.den       (uni_s3),
		.out_ctl   (div_out_ctl),
		.out_ready (en_o),
		.quot      (div_quot),
		.rem       (div_rem)
	);

	// inter*2^F > thr*union holds when the quotient beats thr,
	// or equals it with a remainder left over
	logic [CW-1:0] quot_ext, thr_ext;
	logic          match_nx;

	always_comb begin
		quot_ext = CW'(div_quot);
		thr_ext  = CW'(thr_q);
		match_nx = ~div_out_ctl.empty &
			((quot_ext > thr_ext) | ((quot_ext == thr_ext) & (div_rem != '0)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en_o) begin
			out_vld_q <= div_out_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_o) begin
			iou_q   <= div_out_ctl.empty ? '0 : IOU_W'(quot_ext);
			match_q <= match_nx;
			empty_q <= div_out_ctl.empty;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(OUT_W - OUT_FLD_W){1'b0}}, empty_q, match_q, iou_q};

endmodule

`default_nettype wire

[design/biou_chk.sv]
// port-level checks on the result stream of the box iou block, bound to the top
// depends on biou_pkg and the assertion macro header
`default_nettype none
`include "box_intersection_over_union_top_defines.svh"

module biou_chk
	import biou_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             m_axis_tvalid,
	input  wire logic             m_axis_tready,
	input  wire logic [OUT_W-1:0] m_axis_tdata
);

	// largest iou that fits the field: one point zero, or all ones when truncated
	localparam logic [IOU_W-1:0] IOU_LIM =
		(FRAC_BITS < IOU_W) ? (IOU_W'(1) << FRAC_BITS) : {IOU_W{1'b1}};

	`BIOU_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
	`BIOU_ASSERT(a_empty_zero, m_axis_tvalid && m_axis_tdata[IOU_W+1] |-> m_axis_tdata[IOU_W:0] == '0, "empty union with nonzero iou or match")
	`BIOU_ASSERT(a_iou_range, m_axis_tvalid |-> m_axis_tdata[IOU_W-1:0] <= IOU_LIM, "iou above one")
	// before the first reset edge the valid flop may still be unknown
	`BIOU_ASSERT_ALWAYS(a_rst_idle, !arst_n |-> m_axis_tvalid !== 1'b1, "result valid during reset")

endmodule

bind box_intersection_over_union_top biou_chk #(
	.FRAC_BITS (FRAC_BITS)
) u_biou_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
